// ===== rtl/core/pcrl_pkg.sv =====
// shared constants, codes and types for the pin check block
package pcrl_pkg;

   // field widths
   localparam int KIND_W     = 2;
   localparam int CHAR_W     = 8;
   localparam int TIME_W     = 32;
   localparam int HASH_W     = 32;
   localparam int STATUS_W   = 3;
   localparam int COUNT_W    = 8;
   localparam int LEN_W      = 7;
   localparam int FAIL_W     = 8;
   localparam int DUR_W      = 31;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 31;

   // salted fnv-1a constants
   localparam logic [HASH_W-1:0] HASH_SEED  = 32'd2166136261;
   localparam logic [HASH_W-1:0] HASH_SALT  = 32'h7A31C5D9;
   localparam logic [HASH_W-1:0] HASH_PRIME = 32'd16777619;
   localparam logic [HASH_W-1:0] HASH_INIT  = HASH_SEED ^ HASH_SALT;

   // transaction kinds
   localparam logic [KIND_W-1:0] KIND_VERIFY = 2'd0;
   localparam logic [KIND_W-1:0] KIND_CHANGE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_NONE   = 2'd3;

   // result status codes
   localparam logic [STATUS_W-1:0] ST_GRANTED   = 3'd0;
   localparam logic [STATUS_W-1:0] ST_DENIED    = 3'd1;
   localparam logic [STATUS_W-1:0] ST_LOCKED    = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NO_INIT   = 3'd3;
   localparam logic [STATUS_W-1:0] ST_CHANGED   = 3'd4;
   localparam logic [STATUS_W-1:0] ST_MALFORMED = 3'd5;
   localparam logic [STATUS_W-1:0] ST_LOADED    = 3'd6;

   // register indexes
   localparam logic [CSR_IDX_W-1:0] CSR_MIN_LEN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_LEN  = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_MAX_FAIL = 2'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_DURATION = 2'd3;

   // register reset values
   localparam logic [LEN_W-1:0]  MIN_LEN_RST  = 7'd4;
   localparam logic [LEN_W-1:0]  MAX_LEN_RST  = 7'd8;
   localparam logic [FAIL_W-1:0] MAX_FAIL_RST = 8'd3;
   localparam logic [DUR_W-1:0]  DURATION_RST = 31'd30000;

   // ascii digit range
   localparam logic [CHAR_W-1:0] DIGIT_LO = 8'h30;
   localparam logic [CHAR_W-1:0] DIGIT_HI = 8'h39;

   typedef struct packed {
      logic [LEN_W-1:0]  min_len;
      logic [LEN_W-1:0]  max_len;
      logic [FAIL_W-1:0] max_fail;
      logic [DUR_W-1:0]  duration;
   } cfg_type;

endpackage

// ===== rtl/core/pcrl_req_if.sv =====
// request channel interface: valid/ready plus pin entry fields
interface pcrl_req_if;
   logic                            valid;
   logic                            ready;
   logic [pcrl_pkg::KIND_W-1:0]     kind;
   logic [pcrl_pkg::CHAR_W-1:0]     pin_char;
   logic                            last_char;
   logic [pcrl_pkg::TIME_W-1:0]     now_ms;
   logic [pcrl_pkg::HASH_W-1:0]     hash_value;

   modport source (output valid, kind, pin_char, last_char, now_ms, hash_value,
                   input ready);
   modport sink   (input valid, kind, pin_char, last_char, now_ms, hash_value,
                   output ready);
endinterface

// ===== rtl/core/pcrl_rsp_if.sv =====
// response channel interface: valid/ready plus check result fields
interface pcrl_rsp_if;
   logic                            valid;
   logic                            ready;
   logic [pcrl_pkg::STATUS_W-1:0]   status;
   logic [pcrl_pkg::TIME_W-1:0]     time_left;
   logic [pcrl_pkg::FAIL_W-1:0]     failure_count;
   logic [pcrl_pkg::HASH_W-1:0]     pin_hash;

   modport source  (output valid, status, time_left, failure_count, pin_hash,
                    input ready);
   modport sink    (input valid, status, time_left, failure_count, pin_hash,
                    output ready);
endinterface

// ===== rtl/core/pcrl_hash_unit.sv =====
// shared fnv-1a round: (a xor b) times prime, registered
module pcrl_hash_unit (
   input  logic                          clock,
   input  logic                          op_en,
   input  logic [pcrl_pkg::HASH_W-1:0]   op_a,
   input  logic [pcrl_pkg::COUNT_W-1:0]  op_b,
   output logic [pcrl_pkg::HASH_W-1:0]   prod
);
   logic [pcrl_pkg::HASH_W-1:0] mixed;
   logic [pcrl_pkg::HASH_W-1:0] prod_in;
   logic [pcrl_pkg::HASH_W-1:0] prod_ff;

   assign mixed   = op_a ^ {{(pcrl_pkg::HASH_W-pcrl_pkg::COUNT_W){1'b0}}, op_b};
   assign prod_in = pcrl_pkg::HASH_W'(mixed * pcrl_pkg::HASH_PRIME);
   assign prod    = prod_ff;

   always_ff @(posedge clock) begin
      if (op_en) begin
         prod_ff <= prod_in;
      end
   end
endmodule

// ===== rtl/core/pcrl_csr.sv =====
// configuration registers with write decode
module pcrl_csr (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             csr_we,
   input  logic [pcrl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcrl_pkg::CSR_DATA_W-1:0]  csr_wdata,
   output pcrl_pkg::cfg_type                cfg
);
   pcrl_pkg::cfg_type cfg_ff;
   pcrl_pkg::cfg_type cfg_in;

   assign cfg = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            pcrl_pkg::CSR_MIN_LEN:  cfg_in.min_len  = csr_wdata[pcrl_pkg::LEN_W-1:0];
            pcrl_pkg::CSR_MAX_LEN:  cfg_in.max_len  = csr_wdata[pcrl_pkg::LEN_W-1:0];
            pcrl_pkg::CSR_MAX_FAIL: cfg_in.max_fail = csr_wdata[pcrl_pkg::FAIL_W-1:0];
            pcrl_pkg::CSR_DURATION: cfg_in.duration = csr_wdata[pcrl_pkg::DUR_W-1:0];
            default:                cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_len  <= pcrl_pkg::MIN_LEN_RST;
         cfg_ff.max_len  <= pcrl_pkg::MAX_LEN_RST;
         cfg_ff.max_fail <= pcrl_pkg::MAX_FAIL_RST;
         cfg_ff.duration <= pcrl_pkg::DURATION_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end
endmodule

// ===== rtl/core/pin_check_with_retry_lockout_top.sv =====
// pin check top level: sequencer, lockout state and response register
// a pin character that is not last goes through accept and one hash round
// the last character takes two rounds of the shared hash multiplier
// (byte, then length) and a decide state; the response is registered from the decide state
// a load is decided in the cycle it is accepted; the response register holds one result while the next
// transaction is accepted in the same cycle it is taken
// synchronous active-high reset clears all control, lockout and config state
module pin_check_with_retry_lockout_top (
   input  logic                             clock,
   input  logic                             reset,
   pcrl_req_if.sink                         req_chan,
   pcrl_rsp_if.source                       rsp_chan,
   input  logic                             csr_we,
   input  logic [pcrl_pkg::CSR_IDX_W-1:0]   csr_index,
   input  logic [pcrl_pkg::CSR_DATA_W-1:0]  csr_wdata
);
   // one-hot sequencer states
   typedef enum logic [2:0] {
      S_IDLE  = 3'b001,
      S_CHAR  = 3'b010,
      S_FINAL = 3'b100
   } state_type;

   state_type state_ff, state_in;

   pcrl_pkg::cfg_type cfg;

   // entry accumulator
   logic [pcrl_pkg::HASH_W-1:0]  running_hash_ff, running_hash_in;
   logic [pcrl_pkg::COUNT_W-1:0] char_count_ff, char_count_in;
   logic                         digits_ff, digits_in;
   logic                         wf_ff, wf_in;

   // captured transaction fields
   logic                         last_ff;
   logic                         change_ff;
   logic [pcrl_pkg::TIME_W-1:0]  now_ff;

   // persistent check state
   logic                         init_ff, init_in;
   logic [pcrl_pkg::HASH_W-1:0]  ref_ff, ref_in;
   logic [pcrl_pkg::FAIL_W-1:0]  failures_ff, failures_in;
   logic                         locked_ff, locked_in;
   logic [pcrl_pkg::TIME_W-1:0]  lock_end_ff, lock_end_in;

   // response register
   logic                           rsp_valid_ff, rsp_valid_in;
   logic [pcrl_pkg::STATUS_W-1:0]  rsp_status_ff, rsp_status_in;
   logic [pcrl_pkg::TIME_W-1:0]    rsp_remain_ff, rsp_remain_in;
   logic [pcrl_pkg::FAIL_W-1:0]    rsp_fail_ff, rsp_fail_in;
   logic [pcrl_pkg::HASH_W-1:0]    rsp_hash_ff, rsp_hash_in;
   logic                           rsp_load;

   // shared hash unit
   logic                          hu_en;
   logic [pcrl_pkg::HASH_W-1:0]   hu_a;
   logic [pcrl_pkg::COUNT_W-1:0]  hu_b;
   logic [pcrl_pkg::HASH_W-1:0]   hu_prod;

   logic                          accept;
   logic                          is_char;
   logic                          is_digit;

   // decide-cycle helpers
   logic [pcrl_pkg::TIME_W-1:0]   lock_delta;
   logic [pcrl_pkg::TIME_W-1:0]   lock_left;
   logic [pcrl_pkg::FAIL_W-1:0]   fail_base;
   logic [pcrl_pkg::FAIL_W-1:0]   fail_next;
   logic [pcrl_pkg::TIME_W-1:0]   duration_ext;

   pcrl_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   pcrl_hash_unit u_hash (
      .clock (clock),
      .op_en (hu_en),
      .op_a  (hu_a),
      .op_b  (hu_b),
      .prod  (hu_prod)
   );

   // one transaction at a time; the response slot must be free or draining
   assign req_chan.ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;
   assign is_char        = (req_chan.kind == pcrl_pkg::KIND_VERIFY) ||
                           (req_chan.kind == pcrl_pkg::KIND_CHANGE);
   assign is_digit       = (req_chan.pin_char >= pcrl_pkg::DIGIT_LO) &&
                           (req_chan.pin_char <= pcrl_pkg::DIGIT_HI);

   assign rsp_chan.valid         = rsp_valid_ff;
   assign rsp_chan.status        = rsp_status_ff;
   assign rsp_chan.time_left     = rsp_remain_ff;
   assign rsp_chan.failure_count = rsp_fail_ff;
   assign rsp_chan.pin_hash      = rsp_hash_ff;

   // lockout arithmetic, wrap-safe via sign of the difference
   assign lock_delta   = now_ff - lock_end_ff;
   assign lock_left    = lock_end_ff - now_ff;
   assign duration_ext = {1'b0, cfg.duration};

   always_comb begin
      state_in        = state_ff;
      running_hash_in = running_hash_ff;
      char_count_in   = char_count_ff;
      digits_in       = digits_ff;
      wf_in           = wf_ff;
      init_in         = init_ff;
      ref_in          = ref_ff;
      failures_in     = failures_ff;
      locked_in       = locked_ff;
      lock_end_in     = lock_end_ff;
      rsp_load        = 1'b0;
      rsp_status_in   = rsp_status_ff;
      rsp_remain_in   = rsp_remain_ff;
      rsp_fail_in     = rsp_fail_ff;
      rsp_hash_in     = rsp_hash_ff;
      hu_en           = 1'b0;
      hu_a            = running_hash_ff;
      hu_b            = req_chan.pin_char;
      fail_base       = failures_ff;
      fail_next       = failures_ff;

      unique case (state_ff)
         S_IDLE: begin
            if (accept && is_char) begin
               // first round: fold the byte in
               hu_en     = 1'b1;
               hu_a      = running_hash_ff;
               hu_b      = req_chan.pin_char;
               if (char_count_ff != {pcrl_pkg::COUNT_W{1'b1}}) begin
                  char_count_in = char_count_ff + 1'b1;
               end
               digits_in = digits_ff && is_digit;
               state_in  = S_CHAR;
            end else if (accept && (req_chan.kind == pcrl_pkg::KIND_LOAD)) begin
               running_hash_in = pcrl_pkg::HASH_INIT;
               char_count_in   = '0;
               digits_in       = 1'b1;
               ref_in          = req_chan.hash_value;
               init_in         = 1'b1;
               failures_in     = '0;
               locked_in       = 1'b0;
               lock_end_in     = '0;
               rsp_load        = 1'b1;
               rsp_status_in   = pcrl_pkg::ST_LOADED;
               rsp_remain_in   = '0;
               rsp_fail_in     = '0;
               rsp_hash_in     = '0;
            end
         end

         S_CHAR: begin
            if (last_ff) begin
               // second round: fold the length in, then reset the entry
               hu_en           = 1'b1;
               hu_a            = hu_prod;
               hu_b            = char_count_ff;
               wf_in           = digits_ff &&
                                 (char_count_ff >= {1'b0, cfg.min_len}) &&
                                 (char_count_ff <= {1'b0, cfg.max_len});
               running_hash_in = pcrl_pkg::HASH_INIT;
               char_count_in   = '0;
               digits_in       = 1'b1;
               state_in        = S_FINAL;
            end else begin
               running_hash_in = hu_prod;
               state_in        = S_IDLE;
            end
         end

         S_FINAL: begin
            rsp_load      = 1'b1;
            rsp_hash_in   = hu_prod;
            rsp_remain_in = '0;
            state_in      = S_IDLE;
            if (!init_ff) begin
               rsp_status_in = pcrl_pkg::ST_NO_INIT;
               rsp_fail_in   = failures_ff;
            end else if (change_ff) begin
               if (!wf_ff) begin
                  rsp_status_in = pcrl_pkg::ST_MALFORMED;
                  rsp_fail_in   = failures_ff;
               end else begin
                  ref_in        = hu_prod;
                  failures_in   = '0;
                  locked_in     = 1'b0;
                  lock_end_in   = '0;
                  rsp_status_in = pcrl_pkg::ST_CHANGED;
                  rsp_fail_in   = '0;
               end
            end else if (locked_ff && lock_delta[pcrl_pkg::TIME_W-1]) begin
               // still inside the lockout window
               rsp_status_in = pcrl_pkg::ST_LOCKED;
               rsp_remain_in = lock_left;
               rsp_fail_in   = failures_ff;
            end else begin
               // an expired lockout is cleared before the compare
               if (locked_ff) begin
                  locked_in   = 1'b0;
                  lock_end_in = '0;
                  fail_base   = '0;
               end
               fail_next = (fail_base == {pcrl_pkg::FAIL_W{1'b1}}) ?
                           fail_base : fail_base + 1'b1;
               if (wf_ff && (hu_prod == ref_ff)) begin
                  failures_in   = '0;
                  rsp_status_in = pcrl_pkg::ST_GRANTED;
                  rsp_fail_in   = '0;
               end else if (fail_next >= cfg.max_fail) begin
                  failures_in   = '0;
                  locked_in     = 1'b1;
                  lock_end_in   = now_ff + duration_ext;
                  rsp_status_in = pcrl_pkg::ST_LOCKED;
                  rsp_remain_in = duration_ext;
                  rsp_fail_in   = '0;
               end else begin
                  failures_in   = fail_next;
                  rsp_status_in = pcrl_pkg::ST_DENIED;
                  rsp_fail_in   = fail_next;
               end
            end
         end

         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // response slot: filled by the decide cycle or a load, emptied when the response is taken
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_chan.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= S_IDLE;
         running_hash_ff <= pcrl_pkg::HASH_INIT;
         char_count_ff   <= '0;
         digits_ff       <= 1'b1;
         wf_ff           <= 1'b0;
         init_ff         <= 1'b0;
         ref_ff          <= '0;
         failures_ff     <= '0;
         locked_ff       <= 1'b0;
         lock_end_ff     <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         state_ff        <= state_in;
         running_hash_ff <= running_hash_in;
         char_count_ff   <= char_count_in;
         digits_ff       <= digits_in;
         wf_ff           <= wf_in;
         init_ff         <= init_in;
         ref_ff          <= ref_in;
         failures_ff     <= failures_in;
         locked_ff       <= locked_in;
         lock_end_ff     <= lock_end_in;
         rsp_valid_ff    <= rsp_valid_in;
      end
   end

   // payload registers, no reset
   always_ff @(posedge clock) begin
      if (accept) begin
         last_ff   <= req_chan.last_char;
         change_ff <= (req_chan.kind == pcrl_pkg::KIND_CHANGE);
         now_ff    <= req_chan.now_ms;
      end
      if (rsp_load) begin
         rsp_status_ff <= rsp_status_in;
         rsp_remain_ff <= rsp_remain_in;
         rsp_fail_ff   <= rsp_fail_in;
         rsp_hash_ff   <= rsp_hash_in;
      end
   end
endmodule

// ===== rtl/core/pcrl_checker.sv =====
// port-level checker for the pin check top level, with its bind
module pcrl_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            rsp_valid,
   input  logic                            rsp_ready,
   input  logic [pcrl_pkg::STATUS_W-1:0]   rsp_status,
   input  logic [pcrl_pkg::TIME_W-1:0]     rsp_time_left,
   input  logic [pcrl_pkg::FAIL_W-1:0]     rsp_failure_count,
   input  logic [pcrl_pkg::HASH_W-1:0]     rsp_pin_hash
);
   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // nothing is offered right after reset
   assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   // remaining time is reported only for a locked result
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status != pcrl_pkg::ST_LOCKED) |->
         (rsp_time_left == '0))
      else $error("remaining time outside lockout");

   // a load or a grant leaves no failures behind
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && ((rsp_status == pcrl_pkg::ST_LOADED) ||
                    (rsp_status == pcrl_pkg::ST_GRANTED)) |->
         (rsp_failure_count == '0))
      else $error("failure count not cleared");

   // a load carries no hash
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && (rsp_status == pcrl_pkg::ST_LOADED) |->
         (rsp_pin_hash == '0))
      else $error("load response carries a hash");
endmodule

bind pin_check_with_retry_lockout_top pcrl_checker u_pcrl_checker (
   .clock             (clock),
   .reset             (reset),
   .rsp_valid         (rsp_chan.valid),
   .rsp_ready         (rsp_chan.ready),
   .rsp_status        (rsp_chan.status),
   .rsp_time_left     (rsp_chan.time_left),
   .rsp_failure_count (rsp_chan.failure_count),
   .rsp_pin_hash      (rsp_chan.pin_hash)
);
